@@ hdl/qts_pkg.sv @@
package qts_pkg;

    // Internal arithmetic: 64-bit signed values, magnitudes held below 2^62
    localparam int VAL_W     = 64;
    localparam int MAG_W     = 62;
    localparam int UQ        = 30;          // fraction bits of normalized time
    localparam int MUL_LAT   = 4;           // stages in qts_mul
    localparam int DIVSH_LAT = MAG_W + 2;   // stages in qts_divsh
    localparam int CFG_IDX_W = 2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [MAG_W-1:0]        mag_t;

    // saturation bound on every intermediate magnitude
    localparam mag_t LIM = mag_t'(1) << (MAG_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POS,
        REG_STOP_POS,
        REG_STOP_VEL,
        REG_DURATION
    } cfg_reg_t;

    // polynomial weights
    localparam val_t K_3   = 3;
    localparam val_t K_4   = 4;
    localparam val_t K_6   = 6;
    localparam val_t K_7   = 7;
    localparam val_t K_10  = 10;
    localparam val_t K_12  = 12;
    localparam val_t K_15  = 15;
    localparam val_t K_24  = 24;
    localparam val_t K_28  = 28;
    localparam val_t K_30  = 30;
    localparam val_t K_60  = 60;
    localparam val_t K_84  = 84;
    localparam val_t K_120 = 120;
    localparam val_t K_180 = 180;

endpackage

@@ hdl/qts_mul.sv @@
// (a*b) >> SH, truncated toward zero, magnitude saturated; 4 stages
module qts_mul #(
    parameter int SH  = 30,
    parameter int SBW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  qts_pkg::val_t    a,
    input  qts_pkg::val_t    b,
    input  logic [SBW-1:0]   in_sb,
    output logic             out_valid,
    output qts_pkg::val_t    p,
    output logic [SBW-1:0]   out_sb
);
    import qts_pkg::*;

    localparam int HW = MAG_W / 2;
    localparam int PW = 2 * MAG_W;

    // stage 0: magnitudes
    mag_t            ma_reg, mb_reg, ma_next, mb_next;
    logic            neg0_reg, vld0_reg;
    logic [SBW-1:0]  sb0_reg;
    // stage 1: partial products
    logic [2*HW-1:0] pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic            neg1_reg, vld1_reg;
    logic [SBW-1:0]  sb1_reg;
    // stage 2: full product
    logic [PW-1:0]   full_reg, full_next;
    logic            neg2_reg, vld2_reg;
    logic [SBW-1:0]  sb2_reg;
    // stage 3: shifted, saturated, signed
    val_t            p_reg, p_next;
    logic            vld3_reg;
    logic [SBW-1:0]  sb3_reg;
    logic [PW-1:0]   shd;
    mag_t            mres;

    always_comb
    begin
        ma_next = a[VAL_W-1] ? MAG_W'(-a) : MAG_W'(a);
        mb_next = b[VAL_W-1] ? MAG_W'(-b) : MAG_W'(b);
    end

    always_comb
    begin
        full_next = (PW'(pp11_reg) << (2*HW))
                  + ((PW'(pp01_reg) + PW'(pp10_reg)) << HW)
                  + PW'(pp00_reg);
    end

    always_comb
    begin
        shd = full_reg >> SH;
        if ((|shd[PW-1:MAG_W]) || (shd[MAG_W-1:0] > LIM))
            mres = LIM;
        else
            mres = shd[MAG_W-1:0];
        p_next = neg2_reg ? -val_t'(mres) : val_t'(mres);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg0_reg <= a[VAL_W-1] ^ b[VAL_W-1];
        sb0_reg  <= in_sb;

        pp00_reg <= ma_reg[HW-1:0]     * mb_reg[HW-1:0];
        pp01_reg <= ma_reg[HW-1:0]     * mb_reg[MAG_W-1:HW];
        pp10_reg <= ma_reg[MAG_W-1:HW] * mb_reg[HW-1:0];
        pp11_reg <= ma_reg[MAG_W-1:HW] * mb_reg[MAG_W-1:HW];
        neg1_reg <= neg0_reg;
        sb1_reg  <= sb0_reg;

        full_reg <= full_next;
        neg2_reg <= neg1_reg;
        sb2_reg  <= sb1_reg;

        p_reg    <= p_next;
        sb3_reg  <= sb2_reg;
    end

    assign out_valid = vld3_reg;
    assign p         = p_reg;
    assign out_sb    = sb3_reg;

    a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (p <= val_t'(LIM)) && (p >= -val_t'(LIM)))
        else $error("product outside saturation bound");

endmodule

@@ hdl/qts_div.sv @@
// restoring divider, one quotient bit per stage; rem_in must be below divisor
module qts_div #(
    parameter int DVW = 31,
    parameter int QB  = 30,
    parameter int SBW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DVW-1:0]   rem_in,
    input  logic [QB-1:0]    num_in,
    input  logic [DVW-1:0]   divisor,
    input  logic [SBW-1:0]   in_sb,
    output logic             out_valid,
    output logic [QB-1:0]    quo,
    output logic [SBW-1:0]   out_sb
);
    logic [DVW-1:0] rem_reg [QB];
    logic [QB-1:0]  num_reg [QB];
    logic [SBW-1:0] sb_reg  [QB];
    logic           vld_reg [QB];

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [DVW-1:0] rem_cur;
        logic [QB-1:0]  num_cur;
        logic [SBW-1:0] sb_cur;
        logic           vld_cur;
        logic [DVW:0]   trial;
        logic [DVW:0]   diff;
        logic           ge;
        logic [DVW-1:0] rem_next;
        logic [QB-1:0]  num_next;

        if (i == 0)
        begin : g_first
            assign rem_cur = rem_in;
            assign num_cur = num_in;
            assign sb_cur  = in_sb;
            assign vld_cur = in_valid;
        end
        else
        begin : g_rest
            assign rem_cur = rem_reg[i-1];
            assign num_cur = num_reg[i-1];
            assign sb_cur  = sb_reg[i-1];
            assign vld_cur = vld_reg[i-1];
        end

        // dividend bits leave at the top of num, quotient bits enter at the bottom
        always_comb
        begin
            trial    = {rem_cur, num_cur[QB-1]};
            ge       = trial >= {1'b0, divisor};
            diff     = trial - {1'b0, divisor};
            rem_next = ge ? diff[DVW-1:0] : trial[DVW-1:0];
            num_next = {num_cur[QB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_cur;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= rem_next;
            num_reg[i] <= num_next;
            sb_reg[i]  <= sb_cur;
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign quo       = num_reg[QB-1];
    assign out_sb    = sb_reg[QB-1];

endmodule

@@ hdl/qts_divsh.sv @@
// (a << FB) / divisor, truncated toward zero, magnitude saturated
module qts_divsh #(
    parameter int DVW = 31,
    parameter int FB  = 16,
    parameter int SBW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  qts_pkg::val_t    a,
    input  logic [DVW-1:0]   divisor,
    input  logic [SBW-1:0]   in_sb,
    output logic             out_valid,
    output qts_pkg::val_t    q,
    output logic [SBW-1:0]   out_sb
);
    import qts_pkg::*;

    mag_t             mag;
    mag_t             hi;
    logic [DVW-1:0]   rem_reg, rem_next;
    mag_t             low_reg, low_next;
    logic             ovf_reg, ovf_next;
    logic             neg_reg, vld_reg;
    logic [SBW-1:0]   sb_reg;

    logic             c_vld;
    mag_t             c_quo;
    logic [SBW+1:0]   c_sb;
    mag_t             qm;
    val_t             q_reg, q_next;
    logic             oq_vld_reg;
    logic [SBW-1:0]   oq_sb_reg;

    // quotient bits above the magnitude range come from the top dividend bits
    always_comb
    begin
        mag      = a[VAL_W-1] ? MAG_W'(-a) : MAG_W'(a);
        hi       = mag >> (MAG_W - FB);
        ovf_next = VAL_W'(hi) >= VAL_W'(divisor);
        rem_next = DVW'(hi);
        low_next = mag << FB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= 1'b0;
            oq_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= in_valid;
            oq_vld_reg <= c_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        ovf_reg   <= ovf_next;
        neg_reg   <= a[VAL_W-1];
        sb_reg    <= in_sb;
        q_reg     <= q_next;
        oq_sb_reg <= c_sb[SBW+1:2];
    end

    qts_div #(
        .DVW (DVW),
        .QB  (MAG_W),
        .SBW (SBW + 2)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg),
        .rem_in    (rem_reg),
        .num_in    (low_reg),
        .divisor   (divisor),
        .in_sb     ({sb_reg, neg_reg, ovf_reg}),
        .out_valid (c_vld),
        .quo       (c_quo),
        .out_sb    (c_sb)
    );

    always_comb
    begin
        qm     = (c_sb[0] || (c_quo > LIM)) ? LIM : c_quo;
        q_next = c_sb[1] ? -val_t'(qm) : val_t'(qm);
    end

    assign out_valid = oq_vld_reg;
    assign q         = q_reg;
    assign out_sb    = oq_sb_reg;

endmodule

@@ hdl/quintic_trajectory_sampler.sv @@
// Quintic trajectory sampler, fully pipelined.
// Throughput: one sample per cycle; busy is always low.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Reset (rst_n, async low) clears the config registers and all valid bits.
module quintic_trajectory_sampler #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [DATA_WIDTH-1:0]        query_time,
    input  logic                                cfg_we,
    input  logic [qts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [DATA_WIDTH-1:0]               cfg_data,
    output logic                                done,
    output logic signed [DATA_WIDTH-1:0]        position,
    output logic signed [DATA_WIDTH-1:0]        velocity,
    output logic signed [DATA_WIDTH-1:0]        acceleration,
    output logic                                finished
);
    import qts_pkg::*;

    localparam int DVW = DATA_WIDTH - 1;
    localparam val_t SAT_MAX = (val_t'(1) <<< (DATA_WIDTH - 1)) - val_t'(1);
    localparam val_t SAT_MIN = -SAT_MAX - val_t'(1);
    localparam int LATENCY = 1 + UQ + 4*MUL_LAT + 1 + MUL_LAT + 2*DIVSH_LAT + 1;

    // sideband bundles carried alongside the arithmetic units
    typedef struct packed {
        logic fin;
        val_t u;
        val_t u2;
        val_t vt;
    } sb3_t;

    typedef struct packed {
        logic fin;
        val_t u;
        val_t u2;
        val_t u3;
        val_t vt;
    } sb4_t;

    typedef struct packed {
        logic fin;
        val_t u;
        val_t u2;
        val_t u3;
        val_t u4;
        val_t vt;
    } sb5_t;

    typedef struct packed {
        logic                         fin;
        logic signed [DATA_WIDTH-1:0] pos;
        val_t                         vel_v;
    } sbv_t;

    typedef struct packed {
        logic                         fin;
        logic signed [DATA_WIDTH-1:0] pos;
        logic signed [DATA_WIDTH-1:0] vel;
        val_t                         acc_v;
    } sba_t;

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input val_t x);
        logic signed [DATA_WIDTH-1:0] r;
        if (x > SAT_MAX)
            r = SAT_MAX[DATA_WIDTH-1:0];
        else if (x < SAT_MIN)
            r = SAT_MIN[DATA_WIDTH-1:0];
        else
            r = x[DATA_WIDTH-1:0];
        return r;
    endfunction

    //------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipe
    // is empty (not enforced here), so every stage may read them directly.
    //------------------------------------------------------------------
    logic signed [DATA_WIDTH-1:0] start_pos_reg, stop_pos_reg, stop_vel_reg;
    logic [DVW-1:0]               dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos_reg <= '0;
            stop_pos_reg  <= '0;
            stop_vel_reg  <= '0;
            dur_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_START_POS: start_pos_reg <= cfg_data;
                REG_STOP_POS:  stop_pos_reg  <= cfg_data;
                REG_STOP_VEL:  stop_vel_reg  <= cfg_data;
                REG_DURATION:  dur_reg       <= cfg_data[DVW-1:0];
                default:       ;
            endcase
        end
    end

    // No loop-carried state: a new sample enters every cycle.
    assign busy = 1'b0;

    val_t v_val, t_val;
    assign v_val = val_t'(stop_vel_reg);
    assign t_val = val_t'(dur_reg);

    //------------------------------------------------------------------
    // Input stage: detect the end-of-move case and clamp t to >= 0.
    // Finished samples still flow down the pipe; their arithmetic is
    // discarded at the output mux.
    //------------------------------------------------------------------
    logic           in_vld_reg, in_fin_reg, in_fin_next;
    logic [DVW-1:0] in_t_reg, in_t_next;

    always_comb
    begin
        in_fin_next = (dur_reg == '0) || (query_time >= $signed({1'b0, dur_reg}));
        in_t_next   = query_time[DATA_WIDTH-1] ? '0 : query_time[DVW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        in_fin_reg <= in_fin_next;
        in_t_reg   <= in_t_next;
    end

    //------------------------------------------------------------------
    // u = t / T in Q30: 30-stage restoring divider (t < T unless finished).
    //------------------------------------------------------------------
    logic          u_vld, u_fin;
    logic [UQ-1:0] u_q;
    val_t          u_val;

    qts_div #(
        .DVW (DVW),
        .QB  (UQ),
        .SBW (1)
    ) u_udiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_vld_reg),
        .rem_in    (in_t_reg),
        .num_in    ('0),
        .divisor   (dur_reg),
        .in_sb     (in_fin_reg),
        .out_valid (u_vld),
        .quo       (u_q),
        .out_sb    (u_fin)
    );

    assign u_val = val_t'(u_q);

    //------------------------------------------------------------------
    // Power chain u^2..u^5, with v*T computed beside the first product.
    //------------------------------------------------------------------
    logic m2_vld, mvt_vld, m3_vld, m4_vld, m5_vld, mvt_fin;
    val_t u2, m2_u, vt, u3, u4, u5;
    sb3_t sb3_in, sb3_out;
    sb4_t sb4_in, sb4_out;
    sb5_t sb5_in, sb5_out;

    qts_mul #(.SH(UQ), .SBW(VAL_W)) u_m2 (
        .clk(clk), .rst_n(rst_n), .in_valid(u_vld),
        .a(u_val), .b(u_val), .in_sb(u_val),
        .out_valid(m2_vld), .p(u2), .out_sb(m2_u)
    );

    qts_mul #(.SH(FRAC_BITS), .SBW(1)) u_mvt (
        .clk(clk), .rst_n(rst_n), .in_valid(u_vld),
        .a(v_val), .b(t_val), .in_sb(u_fin),
        .out_valid(mvt_vld), .p(vt), .out_sb(mvt_fin)
    );

    assign sb3_in = '{fin: mvt_fin, u: m2_u, u2: u2, vt: vt};

    qts_mul #(.SH(UQ), .SBW($bits(sb3_t))) u_m3 (
        .clk(clk), .rst_n(rst_n), .in_valid(m2_vld && mvt_vld),
        .a(u2), .b(m2_u), .in_sb(sb3_in),
        .out_valid(m3_vld), .p(u3), .out_sb(sb3_out)
    );

    assign sb4_in = '{fin: sb3_out.fin, u: sb3_out.u, u2: sb3_out.u2, u3: u3,
                      vt: sb3_out.vt};

    qts_mul #(.SH(UQ), .SBW($bits(sb4_t))) u_m4 (
        .clk(clk), .rst_n(rst_n), .in_valid(m3_vld),
        .a(u3), .b(sb3_out.u), .in_sb(sb4_in),
        .out_valid(m4_vld), .p(u4), .out_sb(sb4_out)
    );

    assign sb5_in = '{fin: sb4_out.fin, u: sb4_out.u, u2: sb4_out.u2,
                      u3: sb4_out.u3, u4: u4, vt: sb4_out.vt};

    qts_mul #(.SH(UQ), .SBW($bits(sb5_t))) u_m5 (
        .clk(clk), .rst_n(rst_n), .in_valid(m4_vld),
        .a(u4), .b(sb4_out.u), .in_sb(sb5_in),
        .out_valid(m5_vld), .p(u5), .out_sb(sb5_out)
    );

    //------------------------------------------------------------------
    // Basis polynomials in Q30. Small constant weights: shift-and-add.
    //   pp_*: position, vp_*: velocity, ap_*: acceleration
    //   *_d weights the distance, *_v the stop velocity
    //------------------------------------------------------------------
    logic poly_vld_reg, poly_fin_reg;
    val_t pp_d_reg, pp_v_reg, vp_d_reg, vp_v_reg, ap_d_reg, ap_v_reg;
    val_t pp_d_next, pp_v_next, vp_d_next, vp_v_next, ap_d_next, ap_v_next;
    val_t d_reg, d_next, vt_reg;

    always_comb
    begin
        pp_d_next = K_10*sb5_out.u3 - K_15*sb5_out.u4 + K_6*u5;
        pp_v_next = K_7*sb5_out.u4 - K_4*sb5_out.u3 - K_3*u5;
        vp_d_next = K_30*sb5_out.u2 - K_60*sb5_out.u3 + K_30*sb5_out.u4;
        vp_v_next = K_28*sb5_out.u3 - K_12*sb5_out.u2 - K_15*sb5_out.u4;
        ap_d_next = K_60*sb5_out.u - K_180*sb5_out.u2 + K_120*sb5_out.u3;
        ap_v_next = K_84*sb5_out.u2 - K_24*sb5_out.u - K_60*sb5_out.u3;
        d_next    = val_t'(stop_pos_reg) - val_t'(start_pos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_vld_reg <= 1'b0;
        else
            poly_vld_reg <= m5_vld;
    end

    always_ff @(posedge clk)
    begin
        poly_fin_reg <= sb5_out.fin;
        pp_d_reg     <= pp_d_next;
        pp_v_reg     <= pp_v_next;
        vp_d_reg     <= vp_d_next;
        vp_v_reg     <= vp_v_next;
        ap_d_reg     <= ap_d_next;
        ap_v_reg     <= ap_v_next;
        d_reg        <= d_next;
        vt_reg       <= sb5_out.vt;
    end

    //------------------------------------------------------------------
    // Six weighting products in parallel lanes.
    //------------------------------------------------------------------
    logic [5:0] mul_vld, mul_fin;
    val_t       mp_d, mp_v, mv_d, mv_v, ma_d, ma_v;
    logic       w_vld, w_fin;

    qts_mul #(.SH(UQ), .SBW(1)) u_mp_d (
        .clk(clk), .rst_n(rst_n), .in_valid(poly_vld_reg),
        .a(d_reg), .b(pp_d_reg), .in_sb(poly_fin_reg),
        .out_valid(mul_vld[0]), .p(mp_d), .out_sb(mul_fin[0])
    );

    qts_mul #(.SH(UQ), .SBW(1)) u_mp_v (
        .clk(clk), .rst_n(rst_n), .in_valid(poly_vld_reg),
        .a(vt_reg), .b(pp_v_reg), .in_sb(poly_fin_reg),
        .out_valid(mul_vld[1]), .p(mp_v), .out_sb(mul_fin[1])
    );

    qts_mul #(.SH(UQ), .SBW(1)) u_mv_d (
        .clk(clk), .rst_n(rst_n), .in_valid(poly_vld_reg),
        .a(d_reg), .b(vp_d_reg), .in_sb(poly_fin_reg),
        .out_valid(mul_vld[2]), .p(mv_d), .out_sb(mul_fin[2])
    );

    qts_mul #(.SH(UQ), .SBW(1)) u_mv_v (
        .clk(clk), .rst_n(rst_n), .in_valid(poly_vld_reg),
        .a(v_val), .b(vp_v_reg), .in_sb(poly_fin_reg),
        .out_valid(mul_vld[3]), .p(mv_v), .out_sb(mul_fin[3])
    );

    qts_mul #(.SH(UQ), .SBW(1)) u_ma_d (
        .clk(clk), .rst_n(rst_n), .in_valid(poly_vld_reg),
        .a(d_reg), .b(ap_d_reg), .in_sb(poly_fin_reg),
        .out_valid(mul_vld[4]), .p(ma_d), .out_sb(mul_fin[4])
    );

    qts_mul #(.SH(UQ), .SBW(1)) u_ma_v (
        .clk(clk), .rst_n(rst_n), .in_valid(poly_vld_reg),
        .a(v_val), .b(ap_v_reg), .in_sb(poly_fin_reg),
        .out_valid(mul_vld[5]), .p(ma_v), .out_sb(mul_fin[5])
    );

    // lanes run in lockstep
    assign w_vld = &mul_vld;
    assign w_fin = &mul_fin;

    //------------------------------------------------------------------
    // First division rank: velocity distance term and both acceleration
    // terms. Position is complete here and rides along.
    //------------------------------------------------------------------
    sbv_t sbv_in, sbv_out;
    logic dv_vld, da1_vld, da2_vld, da1_fin, da2_fin;
    val_t q_v, q_a1, q_a2;

    assign sbv_in = '{fin: w_fin,
                      pos: sat_dw(val_t'(start_pos_reg) + mp_d + mp_v),
                      vel_v: mv_v};

    qts_divsh #(.DVW(DVW), .FB(FRAC_BITS), .SBW($bits(sbv_t))) u_dv (
        .clk(clk), .rst_n(rst_n), .in_valid(w_vld),
        .a(mv_d), .divisor(dur_reg), .in_sb(sbv_in),
        .out_valid(dv_vld), .q(q_v), .out_sb(sbv_out)
    );

    qts_divsh #(.DVW(DVW), .FB(FRAC_BITS), .SBW(1)) u_da1 (
        .clk(clk), .rst_n(rst_n), .in_valid(w_vld),
        .a(ma_d), .divisor(dur_reg), .in_sb(w_fin),
        .out_valid(da1_vld), .q(q_a1), .out_sb(da1_fin)
    );

    qts_divsh #(.DVW(DVW), .FB(FRAC_BITS), .SBW(1)) u_da2 (
        .clk(clk), .rst_n(rst_n), .in_valid(w_vld),
        .a(ma_v), .divisor(dur_reg), .in_sb(w_fin),
        .out_valid(da2_vld), .q(q_a2), .out_sb(da2_fin)
    );

    //------------------------------------------------------------------
    // Second division rank: the distance term of acceleration is divided
    // by T once more (d/T^2 as two truncating divisions).
    //------------------------------------------------------------------
    sba_t sba_in, sba_out;
    logic db_vld;
    val_t q_a3;

    assign sba_in = '{fin: sbv_out.fin & da1_fin & da2_fin,
                      pos: sbv_out.pos,
                      vel: sat_dw(q_v + sbv_out.vel_v),
                      acc_v: q_a2};

    qts_divsh #(.DVW(DVW), .FB(FRAC_BITS), .SBW($bits(sba_t))) u_db (
        .clk(clk), .rst_n(rst_n), .in_valid(dv_vld && da1_vld && da2_vld),
        .a(q_a1), .divisor(dur_reg), .in_sb(sba_in),
        .out_valid(db_vld), .q(q_a3), .out_sb(sba_out)
    );

    //------------------------------------------------------------------
    // Output register: end-of-move samples take the stop values.
    //------------------------------------------------------------------
    logic                         done_reg, fin_reg;
    logic signed [DATA_WIDTH-1:0] pos_reg, vel_reg, acc_reg;
    logic signed [DATA_WIDTH-1:0] pos_next, vel_next, acc_next;

    always_comb
    begin
        if (sba_out.fin)
        begin
            pos_next = stop_pos_reg;
            vel_next = stop_vel_reg;
            acc_next = '0;
        end
        else
        begin
            pos_next = sba_out.pos;
            vel_next = sba_out.vel;
            acc_next = sat_dw(q_a3 + sba_out.acc_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= db_vld;
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= sba_out.fin;
        pos_reg <= pos_next;
        vel_reg <= vel_next;
        acc_reg <= acc_next;
    end

    assign done         = done_reg;
    assign finished     = fin_reg;
    assign position     = pos_reg;
    assign velocity     = vel_reg;
    assign acceleration = acc_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing at fixed latency");

    a_fin_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> (acceleration == '0))
        else $error("finished sample with nonzero acceleration");

    a_fin_vals: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> (position == stop_pos_reg) && (velocity == stop_vel_reg))
        else $error("finished sample not at stop values");

    a_zero_dur: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !finished) |-> (dur_reg != '0))
        else $error("running sample with zero duration");

endmodule

@@ sim/quintic_trajectory_sampler_tb.sv @@
module quintic_trajectory_sampler_tb;
    import qts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW       = 32;
    localparam int FB       = 16;
    localparam int NFRAC_U  = 30;          // fraction bits of normalized time
    localparam int PIPE_LAT = 181;         // start to done, as LATENCY in the RTL
    localparam int SETTLE   = PIPE_LAT + 20;
    localparam int WDOG_MAX = 5000;        // cycles with no item moving either way
    localparam longint SAT_LIM = longint'(1) << 61;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [DW-1:0] query_time;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DW-1:0] cfg_data;
    logic done;
    logic signed [DW-1:0] position;
    logic signed [DW-1:0] velocity;
    logic signed [DW-1:0] acceleration;
    logic finished;

    quintic_trajectory_sampler #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .query_time(query_time), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .position(position),
        .velocity(velocity), .acceleration(acceleration), .finished(finished)
    );

    typedef struct {
        logic [DW-1:0] pos;
        logic [DW-1:0] vel;
        logic [DW-1:0] acc;
        logic          fin;
    } traj_pt_t;

    // directed stimulus row: setup, sample time, and a typed-in answer when known
    typedef struct {
        logic [DW-1:0] p0;
        logic [DW-1:0] p1;
        logic [DW-1:0] v1;
        logic [DW-1:0] dur;
        logic [DW-1:0] t;
        bit            known;
        logic [DW-1:0] pos;
        logic [DW-1:0] vel;
        logic [DW-1:0] acc;
        logic          fin;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        // reset setup: zero duration, everything jumps to the (zero) end point
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h00000000, 1, 32'h0, 32'h0, 32'h0, 1'b1},
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 1, 32'h0, 32'h0, 32'h0, 1'b1},
        '{32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff, 1, 32'h0, 32'h0, 32'h0, 1'b1},
        // 1.0 -> 5.0 over 2 s, ending at 0.5 units/s
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h80000000, 1,
          32'h10000, 32'h0, 32'h0, 1'b0},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h00000000, 1,
          32'h10000, 32'h0, 32'h0, 1'b0},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h00000001, 0, 0, 0, 0, 0},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h00008000, 0, 0, 0, 0, 0},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h00010000, 0, 0, 0, 0, 0},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h0001ffff, 0, 0, 0, 0, 0},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h00020000, 1,
          32'h50000, 32'h8000, 32'h0, 1'b1},
        '{32'h10000, 32'h50000, 32'h8000, 32'h20000, 32'h7fffffff, 1,
          32'h50000, 32'h8000, 32'h0, 1'b1},
        // full-scale move over the longest duration
        '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0, 1,
          32'h80000000, 32'h0, 32'h0, 1'b0},
        '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1, 0, 0, 0, 0, 0},
        '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h40000000,
          0, 0, 0, 0, 0},
        '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7ffffffe,
          0, 0, 0, 0, 0},
        '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1,
          32'h7fffffff, 32'h80000000, 32'h0, 1'b1},
        // shortest nonzero duration, reversed extremes
        '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1, 32'h0, 1,
          32'h7fffffff, 32'h0, 32'h0, 1'b0},
        '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff, 1,
          32'h7fffffff, 32'h0, 32'h0, 1'b0},
        '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1, 32'h1, 1,
          32'h80000000, 32'h7fffffff, 32'h0, 1'b1},
        // zero duration with a live setup
        '{32'h12345678, 32'hfedcba98, 32'h00030000, 32'h0, 32'h00001234, 1,
          32'hfedcba98, 32'h00030000, 32'h0, 1'b1},
        '{32'h12345678, 32'hfedcba98, 32'h00030000, 32'h0, 32'hedcba987, 1,
          32'hfedcba98, 32'h00030000, 32'h0, 1'b1}
    };

    // setup register shadow: duration zero extended, the rest sign extended
    longint sh_p0, sh_p1, sh_v1, sh_dur;
    traj_pt_t pending_pts[$];
    int idle_pct;
    int n_err;
    int wdog;

    // (a*b) >> sh toward zero, magnitude held at SAT_LIM
    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic [127:0] ua, ub, p;
        longint m;
        ua = {64'd0, (a < 0) ? -a : a};
        ub = {64'd0, (b < 0) ? -b : b};
        p = (ua * ub) >> sh;
        m = (p > SAT_LIM) ? SAT_LIM : longint'(p[63:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // (a << sh) / b toward zero, b > 0
    function automatic longint div_trunc(longint a, longint b, int sh);
        logic [127:0] ua, q;
        longint m;
        if (b <= 0)
            return 0;
        ua = {64'd0, (a < 0) ? -a : a};
        q = (ua << sh) / {64'd0, b};
        m = (q > SAT_LIM) ? SAT_LIM : longint'(q[63:0]);
        return (a < 0) ? -m : m;
    endfunction

    function automatic longint hold_lim(longint x);
        if (x > SAT_LIM) return SAT_LIM;
        if (x < -SAT_LIM) return -SAT_LIM;
        return x;
    endfunction

    function automatic logic [DW-1:0] to_out(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[DW-1:0];
    endfunction

    // trajectory sample at time t under the shadow setup
    function automatic traj_pt_t trajectory_at(logic [DW-1:0] t_raw);
        traj_pt_t r;
        longint t, u, u2, u3, u4, u5, d, vt, pos, vel, acc;
        t = longint'($signed(t_raw));
        if (sh_dur <= 0 || t >= sh_dur) begin
            r.pos = to_out(sh_p1);
            r.vel = to_out(sh_v1);
            r.acc = '0;
            r.fin = 1'b1;
            return r;
        end
        if (t < 0)
            t = 0;
        u  = (t << NFRAC_U) / sh_dur;
        u2 = mul_trunc(u, u, NFRAC_U);
        u3 = mul_trunc(u2, u, NFRAC_U);
        u4 = mul_trunc(u3, u, NFRAC_U);
        u5 = mul_trunc(u4, u, NFRAC_U);
        d  = sh_p1 - sh_p0;
        vt = mul_trunc(sh_v1, sh_dur, FB);
        pos = hold_lim(sh_p0
            + mul_trunc(d, 10 * u3 - 15 * u4 + 6 * u5, NFRAC_U)
            + mul_trunc(vt, -4 * u3 + 7 * u4 - 3 * u5, NFRAC_U));
        vel = hold_lim(div_trunc(mul_trunc(d, 30 * u2 - 60 * u3 + 30 * u4, NFRAC_U),
                                 sh_dur, FB)
            + mul_trunc(sh_v1, -12 * u2 + 28 * u3 - 15 * u4, NFRAC_U));
        acc = hold_lim(div_trunc(div_trunc(mul_trunc(d, 60 * u - 180 * u2 + 120 * u3,
                                                     NFRAC_U), sh_dur, FB), sh_dur, FB)
            + div_trunc(mul_trunc(sh_v1, -24 * u + 84 * u2 - 60 * u3, NFRAC_U),
                        sh_dur, FB));
        r.pos = to_out(pos);
        r.vel = to_out(vel);
        r.acc = to_out(acc);
        r.fin = 1'b0;
        return r;
    endfunction

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // wait out every pending sample, then let the pipeline empty
    task automatic drain_pipe();
        while (pending_pts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= val;
        @(posedge clk);
        case (r)
            REG_START_POS: sh_p0  = longint'($signed(val));
            REG_STOP_POS:  sh_p1  = longint'($signed(val));
            REG_STOP_VEL:  sh_v1  = longint'($signed(val));
            REG_DURATION:  sh_dur = longint'({1'b0, val[DW-2:0]});
            default: ;
        endcase
    endtask

    // setup is only touched with the pipeline empty
    task automatic load_setup(logic [DW-1:0] p0, logic [DW-1:0] p1,
                              logic [DW-1:0] v1, logic [DW-1:0] dur);
        drain_pipe();
        write_reg(REG_START_POS, p0);
        write_reg(REG_STOP_POS, p1);
        write_reg(REG_STOP_VEL, v1);
        write_reg(REG_DURATION, dur);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // present one sample; idle_pct sets the chance of a gap before it
    task automatic send_sample(logic [DW-1:0] t, bit known, traj_pt_t typed);
        while ($urandom_range(99) < idle_pct) begin
            start      <= 1'b0;
            query_time <= $urandom;
            @(posedge clk);
        end
        start      <= 1'b1;
        query_time <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_pts.push_back(known ? typed : trajectory_at(t));
    endtask

    function automatic logic [DW-1:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom;
            default: return ($urandom_range(1)) ? $urandom_range(32'h3fffff)
                                               : -$urandom_range(32'h3fffff);
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_duration();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'h7fffffff;
            3: return $urandom >> 1;
            default: return $urandom_range(32'h80000, 32'h100);
        endcase
    endfunction

    // mostly samples inside the move, some past the end, some anywhere
    function automatic logic [DW-1:0] rand_time();
        int r;
        r = $urandom_range(99);
        if (sh_dur == 0 || r < 10)
            return $urandom;
        if (r < 22)
            return DW'(sh_dur) + DW'($urandom_range(32'h1000));
        if (r < 27)
            return 32'h0;
        return $urandom_range(32'(sh_dur - 1), 0);
    endfunction

    // result checker: done marks one result, accepted at the edge that ends it
    always @(posedge clk) begin
        traj_pt_t e;
        if (rst_n && done) begin
            if (pending_pts.size() == 0) begin
                $error("result with no sample outstanding");
                n_err++;
            end else begin
                e = pending_pts.pop_front();
                if (position !== e.pos) begin
                    $error("position exp %h got %h", e.pos, position);
                    n_err++;
                end
                if (velocity !== e.vel) begin
                    $error("velocity exp %h got %h", e.vel, velocity);
                    n_err++;
                end
                if (acceleration !== e.acc) begin
                    $error("acceleration exp %h got %h", e.acc, acceleration);
                    n_err++;
                end
                if (finished !== e.fin) begin
                    $error("finished exp %b got %b", e.fin, finished);
                    n_err++;
                end
            end
        end
    end

    // watchdog: counts cycles in which no item moves in or out
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        traj_pt_t typed;
        dir_row_t row;
        n_err       = 0;
        wdog        = 0;
        idle_pct    = 15;
        sh_p0       = 0;
        sh_p1       = 0;
        sh_v1       = 0;
        sh_dur      = 0;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        query_time  <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_START_POS;
        cfg_data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; setup reloaded whenever a row asks for a new one
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (longint'($signed(row.p0)) != sh_p0 || longint'($signed(row.p1)) != sh_p1
                || longint'($signed(row.v1)) != sh_v1
                || longint'({1'b0, row.dur[DW-2:0]}) != sh_dur) begin
                start <= 1'b0;
                load_setup(row.p0, row.p1, row.v1, row.dur);
            end
            typed = '{row.pos, row.vel, row.acc, row.fin};
            send_sample(row.t, row.known, typed);
        end

        // random moves: sender gaps 15%, then 59%, then back to back
        for (int seg = 0; seg < 24; seg++) begin
            idle_pct = (seg < 8) ? 15 : (seg < 16) ? 59 : 0;
            start <= 1'b0;
            if (seg % 6 == 0)
                load_setup(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
            else if (seg % 6 == 3)
                load_setup(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h00000100);
            else
                load_setup(rand_word(), rand_word(), rand_word(), rand_duration());
            for (int k = 0; k < 78; k++)
                send_sample(rand_time(), 1'b0, typed);
        end
        start <= 1'b0;

        drain_pipe();
        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/qts_pkg.sv
hdl/qts_mul.sv
hdl/qts_div.sv
hdl/qts_divsh.sv
hdl/quintic_trajectory_sampler.sv
sim/quintic_trajectory_sampler_tb.sv
